// ----- design/keypad_pin_lock_macros.svh -----
// assertion helpers, clocked on clk, muted during reset
`ifndef KEYPAD_PIN_LOCK_MACROS_SVH
`define KEYPAD_PIN_LOCK_MACROS_SVH

`define KPL_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define KPL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define KPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/kpl_pkg.sv -----
package kpl_pkg;

    localparam int unsigned PIN_W = 15;
    localparam logic [PIN_W-1:0] PIN_RESET = 15'd1111;
    localparam logic [4:0] STAR_KEY = 5'd13;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_VERIFY = 2'd1;
    localparam logic [1:0] MODE_NEWPIN = 2'd2;

    localparam logic [2:0] ST_DIGIT        = 3'd0;
    localparam logic [2:0] ST_ENTER_CHANGE = 3'd1;
    localparam logic [2:0] ST_ACCEPTED     = 3'd2;
    localparam logic [2:0] ST_REJECTED     = 3'd3;
    localparam logic [2:0] ST_AUTHORIZED   = 3'd4;
    localparam logic [2:0] ST_CHANGED      = 3'd5;
    localparam logic [2:0] ST_CANCELLED    = 3'd6;

    typedef struct packed {
        logic [1:0] key_row;
        logic [1:0] key_col;
    } key_word_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [4:0]       key_value;
        logic [1:0]       mode;
        logic [PIN_W-1:0] current_pin;
    } result_word_t;

    // classified press handed from front to back
    typedef struct packed {
        logic             is_star;
        logic             is_last;
        logic [4:0]       key_value;
        logic [PIN_W-1:0] term;
    } press_t;

    function automatic logic [4:0] key_decode(input logic [1:0] row, input logic [1:0] col);
        logic [4:0] k;
        case ({row, col})
            4'd0:    k = 5'd1;
            4'd1:    k = 5'd4;
            4'd2:    k = 5'd7;
            4'd3:    k = 5'd13;
            4'd4:    k = 5'd2;
            4'd5:    k = 5'd5;
            4'd6:    k = 5'd8;
            4'd7:    k = 5'd0;
            4'd8:    k = 5'd3;
            4'd9:    k = 5'd6;
            4'd10:   k = 5'd9;
            4'd11:   k = 5'd14;
            4'd12:   k = 5'd10;
            4'd13:   k = 5'd11;
            4'd14:   k = 5'd12;
            default: k = 5'd16;
        endcase
        return k;
    endfunction

    function automatic logic [9:0] digit_weight(input logic [1:0] pos);
        logic [9:0] w;
        case (pos)
            2'd0:    w = 10'd1000;
            2'd1:    w = 10'd100;
            2'd2:    w = 10'd10;
            default: w = 10'd1;
        endcase
        return w;
    endfunction

endpackage

// ----- design/kpl_fifo.sv -----
module kpl_fifo
    import kpl_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/kpl_front.sv -----
module kpl_front
    import kpl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  key_word_t key,
    output press_t    press
);

    // digit position depends only on the key sequence
    logic [1:0]  digit_count_reg, digit_count_next;
    logic [4:0]  key_value;
    logic        is_star;
    logic [14:0] product;

    assign key_value = key_decode(key.key_row, key.key_col);
    assign is_star   = (key_value == STAR_KEY);
    assign product   = 15'(key_value) * 15'(digit_weight(digit_count_reg));

    always_comb
    begin
        press.is_star   = is_star;
        press.is_last   = !is_star && (digit_count_reg == 2'd3);
        press.key_value = key_value;
        press.term      = product;
        digit_count_next = is_star ? 2'd0 : digit_count_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= 2'd0;
        end
        else if (accept)
        begin
            digit_count_reg <= digit_count_next;
        end
    end

endmodule

// ----- design/kpl_back.sv -----
module kpl_back
    import kpl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  press_t           press,
    input  logic             cfg_write,
    input  logic [PIN_W-1:0] cfg_data,
    output result_word_t     result
);

    logic [1:0]       mode_reg, mode_next;
    logic [PIN_W-1:0] code_sum_reg, code_sum_next;
    logic [PIN_W-1:0] active_pin_reg, active_pin_next;
    logic [PIN_W-1:0] sum;
    logic [2:0]       status;
    logic             match;

    assign sum   = code_sum_reg + press.term;
    assign match = (sum == active_pin_reg);

    always_comb
    begin
        mode_next       = mode_reg;
        code_sum_next   = sum;
        active_pin_next = active_pin_reg;
        status          = ST_DIGIT;
        if (press.is_star)
        begin
            code_sum_next = '0;
            if (mode_reg == MODE_NORMAL)
            begin
                mode_next = MODE_VERIFY;
                status    = ST_ENTER_CHANGE;
            end
            else
            begin
                mode_next = MODE_NORMAL;
                status    = ST_CANCELLED;
            end
        end
        else if (press.is_last)
        begin
            code_sum_next = '0;
            mode_next     = MODE_NORMAL;
            case (mode_reg)
                MODE_VERIFY:
                begin
                    mode_next = match ? MODE_NEWPIN : MODE_NORMAL;
                    status    = match ? ST_AUTHORIZED : ST_REJECTED;
                end
                MODE_NEWPIN:
                begin
                    active_pin_next = sum;
                    status          = ST_CHANGED;
                end
                default:
                begin
                    status = match ? ST_ACCEPTED : ST_REJECTED;
                end
            endcase
        end
        result.status      = status;
        result.key_value   = press.key_value;
        result.mode        = mode_next;
        result.current_pin = active_pin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NORMAL;
            code_sum_reg   <= '0;
            active_pin_reg <= PIN_RESET;
        end
        else if (cfg_write)
        begin
            active_pin_reg <= cfg_data;
        end
        else if (take)
        begin
            mode_reg       <= mode_next;
            code_sum_reg   <= code_sum_next;
            active_pin_reg <= active_pin_next;
        end
    end

endmodule

// ----- design/keypad_pin_lock.sv -----
// Four-key PIN lock for a 4x4 keypad. Each pushed word is one press (row,
// column); each press yields one result word with a status, the decoded key,
// the mode after the press and the PIN in force. One word is accepted per cycle
// while the press queue is not full; a result word can be popped once its press
// has passed one stage in the press queue and one in the result queue; the press
// queue parts key decoding from the lock state update. A cfg write loads the PIN
// in force at once; cfg_ready is low while a press waits; write only while idle.
module keypad_pin_lock
    import kpl_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  key_word_t        key,
    output logic             full,
    input  logic             pop,
    output result_word_t     result,
    output logic             empty,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [PIN_W-1:0] cfg_data
);

`include "keypad_pin_lock_macros.svh"

    press_t       press_in, press_out;
    result_word_t back_result;
    logic         in_accept, press_empty, res_full, take;

    assign in_accept = push && !full;
    assign take      = !press_empty && !res_full;
    assign cfg_ready = press_empty;

    kpl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .key    (key),
        .press  (press_in)
    );

    kpl_fifo #(
        .WIDTH ($bits(press_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_press_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (press_in),
        .full    (full),
        .rd_en   (take),
        .rd_data (press_out),
        .empty   (press_empty)
    );

    kpl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .press     (press_out),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .result    (back_result)
    );

    kpl_fifo #(
        .WIDTH ($bits(result_word_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (back_result),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

    `KPL_ASSERT_NEXT(a_push_queued, in_accept, !press_empty, "accepted press not queued")
    `KPL_ASSERT_IMPL(a_mode_legal, !empty, result.mode != 2'd3, "illegal mode on result")
    `KPL_ASSERT_IMPL(a_digit_not_star, !empty && result.status == ST_DIGIT,
                     result.key_value != STAR_KEY, "star reported as digit")
    `KPL_ASSERT_IMPL(a_verdict_normal, !empty && (result.status == ST_CHANGED
                     || result.status == ST_REJECTED || result.status == ST_ACCEPTED
                     || result.status == ST_CANCELLED),
                     result.mode == MODE_NORMAL, "verdict left lock out of normal mode")

endmodule
